// ===== rtl/stpf_pkg.sv =====
`default_nettype none
package stpf_pkg;

  // Sequencer states of the top level, one-hot.
  typedef enum logic [1:0] {
    ST_RUN = 2'b01,  // taking bins
    ST_DIV = 2'b10   // noise-floor division running or result held
  } state_e;

  // Status of the shared divider.
  typedef struct packed {
    logic busy;  // iterations in progress
    logic done;  // quotient valid, held until the next start
  } div_stat_t;

endpackage
`default_nettype wire

// ===== rtl/stpf_div.sv =====
`default_nettype none
module stpf_div #(
  parameter int DVD_W = 35,
  parameter int DVS_W = 11
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [DVD_W-1:0]        dividend_i,
  input  wire logic [DVS_W-1:0]        divisor_i,
  output stpf_pkg::div_stat_t          stat_o,
  output logic      [DVD_W-1:0]        quotient_o
);
  import stpf_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;

  logic [DVS_W:0]   rem_shift;
  logic [DVS_W+1:0] diff;

  // Restoring division, one quotient bit per cycle.
  assign rem_shift = {rem_q, quo_q[DVD_W-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CNT_W'(DVD_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[DVS_W+1]) begin
        rem_d = diff[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_shift[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule
`default_nettype wire

// ===== rtl/spectrum_top_two_peak_finder.sv =====
`default_nettype none
// Bins: one request per cycle while taking a frame, peak and sum update in that cycle.
// Last bin: the noise floor goes through a shared shift-subtract divider, one quotient
// bit a cycle; the result is registered into the output once the output slot is free,
// and bin input is held off until that hand-over, at every frame end.
// A result waiting on the output does not stall bins; only a second frame end does.
// Reset (async, active low) clears frame state and output valid; fft_size returns to 256.
module spectrum_top_two_peak_finder #(
  parameter int MAX_FFT_SIZE = 4096,
  parameter int MAG_WIDTH    = 24
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // config write channel
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic [$clog2(MAX_FFT_SIZE):0]           fft_size_i,
  // bin request channel
  input  wire logic                                    in_valid_i,
  output logic                                         in_ready_o,
  input  wire logic [MAG_WIDTH-1:0]                    bin_magnitude_i,
  input  wire logic                                    last_bin_i,
  // result request channel
  output logic                                         out_valid_o,
  input  wire logic                                    out_ready_i,
  output logic [$clog2(MAX_FFT_SIZE)-2:0]              peak_bin_o,
  output logic [MAG_WIDTH-1:0]                         peak_level_o,
  output logic [$clog2(MAX_FFT_SIZE)-2:0]              runner_up_bin_o,
  output logic [MAG_WIDTH-1:0]                         runner_up_level_o,
  output logic [MAG_WIDTH-1:0]                         floor_level_o
);
  import stpf_pkg::*;

  localparam int POS_W = $clog2(MAX_FFT_SIZE);  // bin position counter
  localparam int CFG_W = POS_W + 1;             // fft_size register
  localparam int BIN_W = POS_W - 1;             // examined bin index
  localparam int SUM_W = MAG_WIDTH + BIN_W;     // running sum

  // ---------------------------------------------------------------------------
  // Configuration: fft_size, clamped to MAX_FFT_SIZE on use.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] fft_size_q;
  logic [CFG_W-1:0] size_eff;
  logic [POS_W-1:0] half;
  logic             half_ok;   // at least one bin examined (fft_size >= 4)
  logic [BIN_W-1:0] divisor;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fft_size_q <= CFG_W'(256);
    end else if (cfg_valid_i && cfg_ready_o) begin
      fft_size_q <= fft_size_i;
    end
  end

  assign size_eff = (fft_size_q > CFG_W'(MAX_FFT_SIZE)) ? CFG_W'(MAX_FFT_SIZE) : fft_size_q;
  assign half     = size_eff[CFG_W-1:1];
  assign half_ok  = (half >= POS_W'(2));
  // half - 1 always fits BIN_W bits since half <= MAX_FFT_SIZE/2
  assign divisor  = BIN_W'(half - POS_W'(1));

  // ---------------------------------------------------------------------------
  // Sequencer and frame state
  // ---------------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [MAG_WIDTH-1:0] best_level_q, best_level_d;
  logic [BIN_W-1:0]     best_bin_q, best_bin_d;
  logic [MAG_WIDTH-1:0] next_level_q, next_level_d;
  logic [BIN_W-1:0]     next_bin_q, next_bin_d;
  logic [SUM_W-1:0]     sum_q, sum_d;

  logic             in_fire;
  logic             examine;
  logic             div_start;
  logic             res_load;
  div_stat_t        div_stat;
  logic [SUM_W-1:0] quotient;

  assign in_ready_o = (state_q == ST_RUN);
  assign in_fire    = in_valid_i && in_ready_o;
  // DC bin and bins at or above fft_size/2 are skipped
  assign examine    = (pos_q != '0) && (pos_q < half);
  assign div_start  = in_fire && last_bin_i;
  // hand the frame result over once the quotient is in and the output slot is free
  assign res_load   = (state_q == ST_DIV) && div_stat.done && (!out_valid_o || out_ready_i);

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    best_level_d = best_level_q;
    best_bin_d   = best_bin_q;
    next_level_d = next_level_q;
    next_bin_d   = next_bin_q;
    sum_d        = sum_q;

    unique case (state_q)
      ST_RUN: begin
        if (in_fire) begin
          if (examine) begin
            sum_d = sum_q + SUM_W'(bin_magnitude_i);
            // strict compares: earlier bin wins a tie
            if (bin_magnitude_i > best_level_q) begin
              next_level_d = best_level_q;
              next_bin_d   = best_bin_q;
              best_level_d = bin_magnitude_i;
              best_bin_d   = pos_q[BIN_W-1:0];
            end else if (bin_magnitude_i > next_level_q) begin
              next_level_d = bin_magnitude_i;
              next_bin_d   = pos_q[BIN_W-1:0];
            end
          end
          // saturate instead of wrapping on overlong frames
          if (pos_q != '1) begin
            pos_d = pos_q + POS_W'(1);
          end
          if (last_bin_i) begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // frame registers hold the peaks until the result is taken over
        if (res_load) begin
          state_d      = ST_RUN;
          pos_d        = '0;
          best_level_d = '0;
          best_bin_d   = '0;
          next_level_d = '0;
          next_bin_d   = '0;
          sum_d        = '0;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RUN;
      pos_q        <= '0;
      best_level_q <= '0;
      best_bin_q   <= '0;
      next_level_q <= '0;
      next_bin_q   <= '0;
      sum_q        <= '0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      best_level_q <= best_level_d;
      best_bin_q   <= best_bin_d;
      next_level_q <= next_level_d;
      next_bin_q   <= next_bin_d;
      sum_q        <= sum_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared divider: sum / (fft_size/2 - 1); started with the sum that
  // includes the last bin.
  // ---------------------------------------------------------------------------
  stpf_div #(
    .DVD_W (SUM_W),
    .DVS_W (BIN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (divisor),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic                 out_valid_q, out_valid_d;
  logic [BIN_W-1:0]     peak_bin_q;
  logic [MAG_WIDTH-1:0] peak_level_q;
  logic [BIN_W-1:0]     ru_bin_q;
  logic [MAG_WIDTH-1:0] ru_level_q;
  logic [MAG_WIDTH-1:0] floor_q;

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      peak_bin_q   <= best_bin_q;
      peak_level_q <= best_level_q;
      ru_bin_q     <= next_bin_q;
      ru_level_q   <= next_level_q;
      // mean never exceeds the largest bin, so the low bits hold it
      floor_q      <= half_ok ? quotient[MAG_WIDTH-1:0] : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign peak_bin_o        = peak_bin_q;
  assign peak_level_o      = peak_level_q;
  assign runner_up_bin_o   = ru_bin_q;
  assign runner_up_level_o = ru_level_q;
  assign floor_level_o     = floor_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_bins_while_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> !in_ready_o)
    else $error("bin request taken while divider busy");

  a_frame_end_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_bin_i) |=> (state_q == ST_DIV) && div_stat.busy)
    else $error("frame end did not start the division");

  a_peak_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_level_q >= next_level_q)
    else $error("runner-up above peak in frame state");

  a_out_runner_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> runner_up_level_o <= peak_level_o)
    else $error("result runner-up above peak");

  a_out_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> floor_level_o <= peak_level_o)
    else $error("noise floor above peak");

endmodule
`default_nettype wire

// ===== bench/spectrum_top_two_peak_finder_tb.sv =====
`timescale 1ns / 100ps

module spectrum_top_two_peak_finder_tb;

  localparam int MAG_W = 24;
  localparam int BIN_W = 11;
  localparam int CFG_W = 13;
  localparam int SUM_W = 35;

  localparam logic [CFG_W-1:0] SIZE_CAP      = 13'd4096;
  localparam logic [CFG_W-1:0] SIZE_AT_RESET = 13'd256;
  localparam logic [CFG_W-1:0] SIZE_MIN      = 13'd4;
  localparam logic [CFG_W-1:0] SIZE_TINY     = 13'd3;
  localparam logic [CFG_W-1:0] SIZE_ALL_ONES = 13'h1FFF;
  localparam logic [11:0]      POS_LIMIT     = 12'd4095;
  localparam logic [MAG_W-1:0] FULL_SCALE    = 24'hFFFFFF;

  // covers a division plus the output register; leave some margin
  localparam int DRAIN_CYCLES     = 48;
  localparam int RANDOM_ITEMS     = 880;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PRESSURE_PHASE   = 4;
  localparam int MAX_GAP          = 8;

  typedef struct packed {
    logic [BIN_W-1:0] peak_bin;
    logic [MAG_W-1:0] peak_level;
    logic [BIN_W-1:0] runner_up_bin;
    logic [MAG_W-1:0] runner_up_level;
    logic [MAG_W-1:0] floor_level;
  } frame_summary_t;

  // one directed request; set_size writes fft_len first, typed uses want as the answer
  typedef struct {
    bit               set_size;
    logic [CFG_W-1:0] fft_len;
    logic [MAG_W-1:0] mag;
    bit               last_flag;
    bit               typed;
    frame_summary_t   want;
  } stim_row_t;

  localparam frame_summary_t SUMMARY_EMPTY = '0;
  // bins 1 and 2 at full scale: the tie goes to bin 1, bin 2 takes second place,
  // floor = 2 * 0xFFFFFF / 127
  localparam frame_summary_t SUMMARY_FULL_SCALE =
    '{11'd1, FULL_SCALE, 11'd2, FULL_SCALE, 24'd264208};

  localparam int N_DIRECTED = 23;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // right after reset a lone DC bin ends the frame: nothing examined
    '{1'b0, 13'd0, 24'h123456, 1'b1, 1'b1, SUMMARY_EMPTY},
    // full-scale frame, DC skipped, equal peaks
    '{1'b0, 13'd0, FULL_SCALE, 1'b0, 1'b0, SUMMARY_EMPTY},
    '{1'b0, 13'd0, FULL_SCALE, 1'b0, 1'b0, SUMMARY_EMPTY},
    '{1'b0, 13'd0, FULL_SCALE, 1'b1, 1'b1, SUMMARY_FULL_SCALE},
    // ties: bin equal to the peak still becomes runner-up, later equal bins lose
    '{1'b0, 13'd0, 24'd7,      1'b0, 1'b0, SUMMARY_EMPTY},
    '{1'b0, 13'd0, 24'd100,    1'b0, 1'b0, SUMMARY_EMPTY},
    '{1'b0, 13'd0, 24'd50,     1'b0, 1'b0, SUMMARY_EMPTY},
    '{1'b0, 13'd0, 24'd100,    1'b0, 1'b0, SUMMARY_EMPTY},
    '{1'b0, 13'd0, 24'd100,    1'b1, 1'b0, SUMMARY_EMPTY},
    // new peak pushes the old one down; short frame keeps the fixed divisor
    '{1'b0, 13'd0, 24'd0,      1'b0, 1'b0, SUMMARY_EMPTY},
    '{1'b0, 13'd0, 24'd10,     1'b0, 1'b0, SUMMARY_EMPTY},
    '{1'b0, 13'd0, 24'd30,     1'b0, 1'b0, SUMMARY_EMPTY},
    '{1'b0, 13'd0, 24'd20,     1'b1, 1'b0, SUMMARY_EMPTY},
    // smallest legal size: only bin 1 counts, bin 2 is past half
    '{1'b1, SIZE_MIN, 24'd5,   1'b0, 1'b0, SUMMARY_EMPTY},
    '{1'b0, 13'd0, 24'd9,      1'b0, 1'b0, SUMMARY_EMPTY},
    '{1'b0, 13'd0, FULL_SCALE, 1'b1, 1'b0, SUMMARY_EMPTY},
    // tiny size: no bin examined, floor forced to zero
    '{1'b1, SIZE_TINY, 24'd0,  1'b0, 1'b0, SUMMARY_EMPTY},
    '{1'b0, 13'd0, FULL_SCALE, 1'b1, 1'b1, SUMMARY_EMPTY},
    // oversized register value acts as the maximum
    '{1'b1, SIZE_ALL_ONES, 24'd1, 1'b0, 1'b0, SUMMARY_EMPTY},
    '{1'b0, 13'd0, 24'd2,      1'b0, 1'b0, SUMMARY_EMPTY},
    '{1'b0, 13'd0, 24'd3,      1'b1, 1'b0, SUMMARY_EMPTY},
    // largest size, one full-scale bin
    '{1'b1, SIZE_CAP, 24'd0,   1'b0, 1'b0, SUMMARY_EMPTY},
    '{1'b0, 13'd0, FULL_SCALE, 1'b1, 1'b0, SUMMARY_EMPTY}
  };

  // ---------------------------------------------------------------------------
  // DUT ports; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             cfg_valid_i     = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] fft_size_i      = SIZE_AT_RESET;
  logic             in_valid_i      = 1'b0;
  logic             in_ready_o;
  logic [MAG_W-1:0] bin_magnitude_i = '0;
  logic             last_bin_i      = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i     = 1'b0;
  logic [BIN_W-1:0] peak_bin_o;
  logic [MAG_W-1:0] peak_level_o;
  logic [BIN_W-1:0] runner_up_bin_o;
  logic [MAG_W-1:0] runner_up_level_o;
  logic [MAG_W-1:0] floor_level_o;

  spectrum_top_two_peak_finder dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .fft_size_i       (fft_size_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .bin_magnitude_i  (bin_magnitude_i),
    .last_bin_i       (last_bin_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .peak_bin_o       (peak_bin_o),
    .peak_level_o     (peak_level_o),
    .runner_up_bin_o  (runner_up_bin_o),
    .runner_up_level_o(runner_up_level_o),
    .floor_level_o    (floor_level_o)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Peak tracker model: own copy of the register and the frame state
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] fft_len_model = SIZE_AT_RESET;
  logic [11:0]      bin_pos       = '0;
  logic [MAG_W-1:0] top_level     = '0;
  logic [BIN_W-1:0] top_bin       = '0;
  logic [MAG_W-1:0] second_level  = '0;
  logic [BIN_W-1:0] second_bin    = '0;
  logic [SUM_W-1:0] level_total   = '0;

  frame_summary_t summary_q [$];  // summaries still owed by the block

  int unsigned mismatch_count  = 0;
  int unsigned results_checked = 0;
  int unsigned bins_sent       = 0;
  int unsigned size_writes     = 0;
  bit          no_idle         = 1'b0;  // both sides run without gaps
  bit          long_hold_req   = 1'b0;  // sink holds its next result back for a while

  // Advances the frame by one bin; returns 1 with the summary when the frame ends.
  function automatic bit track_bin(input logic [MAG_W-1:0] mag, input bit last_flag,
                                   output frame_summary_t summary);
    logic [CFG_W-1:0] eff_len;
    logic [11:0]      half;
    eff_len = (fft_len_model > SIZE_CAP) ? SIZE_CAP : fft_len_model;
    half    = eff_len[CFG_W-1:1];
    summary = '0;
    // DC bin and everything from half upward are skipped
    if (bin_pos >= 12'd1 && bin_pos < half) begin
      level_total += SUM_W'(mag);
      if (mag > top_level) begin
        second_level = top_level;
        second_bin   = top_bin;
        top_level    = mag;
        top_bin      = bin_pos[BIN_W-1:0];
      end else if (mag > second_level) begin
        second_level = mag;
        second_bin   = bin_pos[BIN_W-1:0];
      end
    end
    if (bin_pos < POS_LIMIT) bin_pos++;  // saturates, never wraps
    if (!last_flag) return 1'b0;
    summary.peak_bin        = top_bin;
    summary.peak_level      = top_level;
    summary.runner_up_bin   = second_bin;
    summary.runner_up_level = second_level;
    // fixed divisor, even for a short frame
    summary.floor_level = (half >= 12'd2) ?
                          MAG_W'(level_total / (SUM_W'(half) - SUM_W'(1))) : '0;
    bin_pos      = '0;
    top_level    = '0;
    top_bin      = '0;
    second_level = '0;
    second_bin   = '0;
    level_total  = '0;
    return 1'b1;
  endfunction

  // Mostly wide random values, with zeros, full scale and small values for ties.
  function automatic logic [MAG_W-1:0] pick_magnitude();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return FULL_SCALE;
      2, 3:    return MAG_W'($urandom_range(3, 0));
      default: return MAG_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Bin sender: random gap (none while no_idle), then hold the request until it is taken.
  // Called at a rising edge; the model runs on acceptance.
  // ---------------------------------------------------------------------------
  task automatic send_bin(input logic [MAG_W-1:0] mag, input bit last_flag,
                          input bit typed, input frame_summary_t want);
    int unsigned    gap;
    frame_summary_t summary;
    gap = no_idle ? 0 : $urandom_range(MAX_GAP, 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    bin_magnitude_i <= mag;
    last_bin_i      <= last_flag;
    do @(posedge clk_i); while (!in_ready_o);
    bins_sent++;
    if (track_bin(mag, last_flag, summary))
      summary_q.push_back(typed ? want : summary);
  endtask

  // Register write only once the block has gone quiet: all summaries out,
  // then enough cycles for a division that may still be in flight.
  task automatic set_fft_size(input logic [CFG_W-1:0] value);
    in_valid_i <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    fft_size_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    fft_len_model = value;
    size_writes++;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string what, input logic [MAG_W-1:0] want,
                             input logic [MAG_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
               $time, what, want, want, got, got);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random hold-off per result, one long hold on request
  // ---------------------------------------------------------------------------
  initial begin : sink
    int unsigned hold;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        hold          = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
      end else begin
        hold = no_idle ? 0 : $urandom_range(MAX_GAP, 0);
      end
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Result checker: each accepted summary against the oldest one owed
  always @(posedge clk_i) begin
    frame_summary_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (summary_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual peak %0d@%0d",
                 $time, peak_level_o, peak_bin_o);
        $display("  runner-up %0d@%0d floor %0d",
                 runner_up_level_o, runner_up_bin_o, floor_level_o);
        mismatch_count++;
      end else begin
        want = summary_q.pop_front();
        check_field("peak_bin",        MAG_W'(want.peak_bin),      MAG_W'(peak_bin_o));
        check_field("peak_level",      want.peak_level,            peak_level_o);
        check_field("runner_up_bin",   MAG_W'(want.runner_up_bin), MAG_W'(runner_up_bin_o));
        check_field("runner_up_level", want.runner_up_level,       runner_up_level_o);
        check_field("floor_level",     want.floor_level,           floor_level_o);
        results_checked++;
      end
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_500_000;
    $display("Timeout at %0t ns, %0d results still owed", $time, summary_q.size());
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [CFG_W-1:0] fft_len;
    int unsigned      half;
    int unsigned      frames;
    int unsigned      len;
    int unsigned      pick;
    int unsigned      phase;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, fft_size still at its reset value until a row sets it
    for (int r = 0; r < N_DIRECTED; r++) begin
      if (directed_rows[r].set_size) set_fft_size(directed_rows[r].fft_len);
      send_bin(directed_rows[r].mag, directed_rows[r].last_flag,
               directed_rows[r].typed, directed_rows[r].want);
    end

    // random phases: one fft_size each, several frames, mostly well formed
    phase = 0;
    while (bins_sent < N_DIRECTED + RANDOM_ITEMS) begin
      no_idle = ($urandom_range(4, 0) == 0);
      frames  = $urandom_range(8, 3);
      case ($urandom_range(9, 0))
        0:       fft_len = CFG_W'($urandom_range(3, 0));
        1:       fft_len = SIZE_MIN;
        2:       fft_len = SIZE_CAP;
        3:       fft_len = CFG_W'($urandom_range(8191, 4097));
        4:       fft_len = CFG_W'($urandom);
        default: fft_len = CFG_W'($urandom_range(72, 5));
      endcase
      if (phase == PRESSURE_PHASE) begin
        // sender runs flat out while the sink sits on a result: input must stall
        fft_len = 13'd16;
        frames  = 12;
        no_idle = 1'b1;
      end
      set_fft_size(fft_len);
      if (phase == PRESSURE_PHASE) long_hold_req = 1'b1;
      half = 32'(((fft_len > SIZE_CAP) ? SIZE_CAP : fft_len) >> 1);
      for (int f = 0; f < frames; f++) begin
        if (half > 40) begin
          len = $urandom_range(40, 1);  // big sizes: short frames only
        end else begin
          pick = $urandom_range(9, 0);
          if (pick < 2)       len = $urandom_range(half + 1, 1);
          else if (pick == 2) len = half + $urandom_range(4, 1);
          else                len = (half == 0) ? 1 : half;
        end
        for (int b = 0; b < len; b++)
          send_bin(pick_magnitude(), b == len - 1, 1'b0, SUMMARY_EMPTY);
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d bins and %0d frame summaries over %0d fft_size writes,",
             bins_sent, results_checked, size_writes);
    $display("with tiny, oversized, short and overlong frames and a stalled sink.");
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== spectrum_top_two_peak_finder.f =====
rtl/stpf_pkg.sv
rtl/stpf_div.sv
rtl/spectrum_top_two_peak_finder.sv
bench/spectrum_top_two_peak_finder_tb.sv
